### sv/cqf_pkg.sv
// Shared types, codes and helpers for the circular queue FIFO.
// Used by the front, command queue, back and top-level modules.
`default_nettype none

package cqf_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int WORD_W = 32;

  // operation codes on the input channel
  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_POP  = 2'd1;
  localparam logic [1:0] FUNC_DUMP = 2'd2;
  localparam logic [1:0] FUNC_NOP  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_DUMP,
    CMD_STATUS
  } cmd_op_t;

  // one classified request handed from front to back
  typedef struct packed {
    cmd_op_t                   op;
    ptr_t                      addr;
    ptr_t                      end_addr;
    logic signed [WORD_W-1:0]  word;
    logic [1:0]                status;
  } cmd_t;

  function automatic ptr_t wrap_next(ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

`default_nettype wire

### sv/circular_queue_fifo.sv
// Top level of the circular queue FIFO: front end, command queue, back end.
// Depends on cqf_pkg, cqf_front, cqf_cmd_queue and cqf_back.
//
// Ring-buffer FIFO of DEPTH signed 32-bit words driven by push, pop and dump
// requests. Push, pop and error/empty requests each give one result and run
// at one request per cycle while the output is not stalled and no dump runs;
// the result reaches the output via the command queue, read stage and output
// register. A dump of n stored words gives n results, one per cycle while the
// output is not stalled, since the back end reads the slot memory through its
// single read port; during that time the front keeps accepting requests until
// the two-entry command queue fills, then stalls. Opcode 3 is accepted and
// gives no result. No clearing pass is needed after reset.
`default_nettype none

module circular_queue_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  func,
  input  wire logic signed [cqf_pkg::WORD_W-1:0] push_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       status,
  output logic signed [cqf_pkg::WORD_W-1:0] word,
  output logic                             last
);
  import cqf_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic cmd_push, cmd_full, cmd_valid, cmd_pop;

  cqf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .push_value (push_value),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd)
  );

  cqf_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (front_cmd),
    .full     (cmd_full),
    .valid    (cmd_valid),
    .pop      (cmd_pop),
    .head_cmd (back_cmd)
  );

  cqf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .word      (word),
    .last      (last)
  );

endmodule

`default_nettype wire

### sv/cqf_front.sv
// Front end: accepts requests, tracks head/tail/empty and classifies each
// request into a back-end command. Depends on cqf_pkg.
`default_nettype none

module cqf_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  func,
  input  wire logic signed [cqf_pkg::WORD_W-1:0] push_value,
  input  wire logic                        cmd_full,
  output logic                             cmd_push,
  output cqf_pkg::cmd_t                    cmd
);
  import cqf_pkg::*;

  ptr_t head, head_next;
  ptr_t tail, tail_next;
  logic is_empty, is_empty_next;
  logic accept;

  assign in_stall = cmd_full;
  assign accept   = in_valid && !cmd_full;

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    is_empty_next = is_empty;
    cmd_push      = 1'b0;
    cmd.op        = CMD_STATUS;
    cmd.addr      = head;
    cmd.end_addr  = tail;
    cmd.word      = push_value;
    cmd.status    = ST_OK;
    if (accept) begin
      case (func)
        FUNC_PUSH: begin
          cmd_push = 1'b1;
          if (is_empty) begin
            head_next     = '0;
            tail_next     = '0;
            is_empty_next = 1'b0;
            cmd.op        = CMD_WRITE;
            cmd.addr      = '0;
          end else if (wrap_next(tail) == head) begin
            cmd.op     = CMD_STATUS;
            cmd.status = ST_OVERFLOW;
          end else begin
            tail_next = wrap_next(tail);
            cmd.op    = CMD_WRITE;
            cmd.addr  = wrap_next(tail);
          end
        end
        FUNC_POP: begin
          cmd_push = 1'b1;
          if (is_empty) begin
            cmd.op     = CMD_STATUS;
            cmd.status = ST_UNDERFLOW;
          end else begin
            cmd.op   = CMD_READ;
            cmd.addr = head;
            if (head == tail) begin
              head_next     = '0;
              tail_next     = '0;
              is_empty_next = 1'b1;
            end else begin
              head_next = wrap_next(head);
            end
          end
        end
        FUNC_DUMP: begin
          cmd_push = 1'b1;
          if (is_empty) begin
            cmd.op     = CMD_STATUS;
            cmd.status = ST_EMPTY;
          end else begin
            cmd.op = CMD_DUMP;
          end
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      is_empty <= 1'b1;
    end else begin
      head     <= head_next;
      tail     <= tail_next;
      is_empty <= is_empty_next;
    end
  end

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    is_empty |-> (head == '0) && (tail == '0))
    else $error("empty queue with nonzero pointers");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  a_nop_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_NOP)) |=> $stable(head) && $stable(tail) && $stable(is_empty))
    else $error("unused opcode changed state");

endmodule

`default_nettype wire

### sv/cqf_cmd_queue.sv
// Two-entry command queue between front and back ends.
// Depends on cqf_pkg for the command type.
`default_nettype none

module cqf_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cqf_pkg::cmd_t push_cmd,
  output logic               full,
  output logic               valid,
  input  wire logic          pop,
  output cqf_pkg::cmd_t      head_cmd
);
  import cqf_pkg::*;

  cmd_t entry [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic do_pop;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign head_cmd = entry[rd_ptr];
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/cqf_back.sv
// Back end: slot memory, dump sequencer, read stage and output register.
// Executes commands from the command queue in order. Depends on cqf_pkg.
`default_nettype none

module cqf_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  input  wire cqf_pkg::cmd_t         cmd,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 status,
  output logic signed [cqf_pkg::WORD_W-1:0] word,
  output logic                       last
);
  import cqf_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data;

  // dump sequencer
  logic dumping, dumping_next;
  ptr_t dump_i, dump_i_next;
  ptr_t dump_end, dump_end_next;

  // read stage
  logic p_valid;
  logic p_from_mem, p_from_mem_next;
  logic [1:0] p_status, p_status_next;
  logic signed [WORD_W-1:0] p_word, p_word_next;
  logic p_last, p_last_next;

  logic o_load, p_free, issue;
  logic mem_we, mem_re;
  ptr_t raddr;

  assign o_load = p_valid && (!out_valid || !out_stall);
  assign p_free = !p_valid || o_load;

  always_comb begin
    issue           = 1'b0;
    cmd_pop         = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    raddr           = dump_i;
    dumping_next    = dumping;
    dump_i_next     = dump_i;
    dump_end_next   = dump_end;
    p_from_mem_next = 1'b1;
    p_status_next   = ST_OK;
    p_word_next     = cmd.word;
    p_last_next     = 1'b1;
    if (p_free) begin
      if (dumping) begin
        issue       = 1'b1;
        mem_re      = 1'b1;
        raddr       = dump_i;
        p_last_next = (dump_i == dump_end);
        dump_i_next = wrap_next(dump_i);
        if (dump_i == dump_end) dumping_next = 1'b0;
      end else if (cmd_valid) begin
        issue   = 1'b1;
        cmd_pop = 1'b1;
        case (cmd.op)
          CMD_WRITE: begin
            mem_we          = 1'b1;
            p_from_mem_next = 1'b0;
          end
          CMD_READ: begin
            mem_re = 1'b1;
            raddr  = cmd.addr;
          end
          CMD_DUMP: begin
            mem_re      = 1'b1;
            raddr       = cmd.addr;
            p_last_next = (cmd.addr == cmd.end_addr);
            if (cmd.addr != cmd.end_addr) begin
              dumping_next  = 1'b1;
              dump_i_next   = wrap_next(cmd.addr);
              dump_end_next = cmd.end_addr;
            end
          end
          default: begin
            // error or empty status: no memory access, word is zero
            p_from_mem_next = 1'b0;
            p_status_next   = cmd.status;
            p_word_next     = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[cmd.addr] <= cmd.word;
    if (mem_re) rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dumping   <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      dumping <= dumping_next;
      if (p_free) p_valid <= issue;
      if (o_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dump_i   <= dump_i_next;
    dump_end <= dump_end_next;
    if (issue) begin
      p_from_mem <= p_from_mem_next;
      p_status   <= p_status_next;
      p_word     <= p_word_next;
      p_last     <= p_last_next;
    end
    if (o_load) begin
      status <= p_status;
      word   <= p_from_mem ? rd_data : p_word;
      last   <= p_last;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (word == '0) && last)
    else $error("error result with nonzero word or without last");

  a_dump_holds_queue: assert property (@(posedge clk) disable iff (rst)
    dumping |-> !cmd_pop)
    else $error("command taken during dump");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("memory read and write issued together");

endmodule

`default_nettype wire
